// ----- hdl/command_line_assembler_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef COMMAND_LINE_ASSEMBLER_MACROS_SVH
`define COMMAND_LINE_ASSEMBLER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("command line assembler check failed");

// Next-cycle implication, disabled while reset is held.
`define CLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("command line assembler check failed");

`endif

// ----- hdl/cla_pkg.sv -----
`default_nettype none

package cla_pkg;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef logic [1:0] t_none_idx;
    localparam t_none_idx NONE_LAST = 2'd3;

    localparam logic [7:0] NONE_TEXT [4] = '{8'h6E, 8'h6F, 8'h6E, 8'h65};

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic store;
        logic start_read;
        logic emit_data;
        logic start_none;
        logic emit_none;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_cr;
        logic in_lf;
        logic full;
        logic empty_line;
        logic out_free;
        logic last_data;
        logic last_none;
    } t_dp_sts;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cla_ctrl.sv -----
`default_nettype none

module cla_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_opcode,
    output logic                 o_ready,
    input  wire cla_pkg::t_dp_sts i_sts,
    output cla_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_NONE
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;
    logic   w_accept;

    assign w_accept = i_valid && r_ready;
    assign o_ready  = r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == cla_pkg::OP_CLEAR) begin
                        o_cmd.clear = 1'b1;
                    end else if (i_sts.in_cr) begin
                        // dropped
                    end else if (i_sts.in_lf) begin
                        if (i_sts.empty_line) begin
                            o_cmd.start_none = 1'b1;
                            n_state          = S_NONE;
                        end else begin
                            o_cmd.start_read = 1'b1;
                            n_state          = S_EMIT;
                        end
                    end else if (i_sts.full) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.store = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_data = 1'b1;
                    if (i_sts.last_data) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_NONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_none = 1'b1;
                    if (i_sts.last_none) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cla_dpath.sv -----
`default_nettype none

module cla_dpath #(
    parameter int LINE_MAX = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [7:0]       i_data_byte,
    input  wire cla_pkg::t_dp_cmd i_cmd,
    output cla_pkg::t_dp_sts      o_sts,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [7:0]            o_cmd_char,
    output logic                  o_last_char
);

    localparam int DEPTH = LINE_MAX - 1;
    localparam int CW    = $clog2(LINE_MAX);
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]          r_mem [DEPTH];
    logic [7:0]          r_rd;
    logic [CW-1:0]       r_fill;
    logic [AW-1:0]       r_first;
    logic [CW-1:0]       r_end;
    logic                r_zero;
    logic [AW-1:0]       r_cursor;
    cla_pkg::t_none_idx  r_none_idx;
    logic                r_out_valid;
    logic [7:0]          r_out_char;
    logic                r_out_last;

    logic [AW:0]         w_rd_next;
    logic [AW:0]         w_rd_addr;
    logic                w_rd_en;

    assign w_rd_next = {1'b0, r_cursor} + 1'b1;
    assign w_rd_addr = i_cmd.start_read ? {1'b0, r_first} : w_rd_next;
    assign w_rd_en   = (i_cmd.start_read || i_cmd.emit_data)
                       && (w_rd_addr < (AW + 1)'(DEPTH));

    always_comb begin
        o_sts.in_cr      = (i_data_byte == cla_pkg::CH_CR);
        o_sts.in_lf      = (i_data_byte == cla_pkg::CH_LF);
        o_sts.full       = (r_fill == CW'(DEPTH));
        o_sts.empty_line = (r_end == '0);
        o_sts.out_free   = !r_out_valid || i_ready;
        o_sts.last_data  = (w_rd_next == (AW + 1)'(r_end));
        o_sts.last_none  = (r_none_idx == cla_pkg::NONE_LAST);
    end

    // line store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_fill[AW-1:0]] <= i_data_byte;
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_data) begin
            r_out_char <= cla_pkg::to_lower(r_rd);
            r_out_last <= (w_rd_next == (AW + 1)'(r_end));
        end else if (i_cmd.emit_none) begin
            r_out_char <= cla_pkg::NONE_TEXT[r_none_idx];
            r_out_last <= (r_none_idx == cla_pkg::NONE_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_first     <= '0;
            r_end       <= '0;
            r_zero      <= 1'b0;
            r_cursor    <= '0;
            r_none_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit_data || i_cmd.emit_none) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.start_none) begin
                r_none_idx <= '0;
            end else if (i_cmd.emit_none) begin
                r_none_idx <= r_none_idx + 1'b1;
            end

            if (i_cmd.clear) begin
                r_fill   <= '0;
                r_first  <= '0;
                r_end    <= '0;
                r_zero   <= 1'b0;
                r_cursor <= '0;
            end else begin
                if (i_cmd.start_read) begin
                    r_cursor <= r_first;
                end else if (i_cmd.emit_data) begin
                    r_cursor <= w_rd_next[AW-1:0];
                end

                if (i_cmd.store) begin
                    r_fill <= r_fill + 1'b1;
                    // text past the first zero byte is ignored by the readout
                    if (!r_zero) begin
                        if (i_data_byte == cla_pkg::CH_NUL) begin
                            r_zero <= 1'b1;
                        end else if (!cla_pkg::is_blank(i_data_byte)) begin
                            if (r_end == '0) begin
                                r_first <= r_fill[AW-1:0];
                            end
                            r_end <= r_fill + 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_cmd_char  = r_out_char;
    assign o_last_char = r_out_last;

endmodule

`default_nettype wire

// ----- hdl/command_line_assembler.sv -----
// Command line assembler. Input items are received bytes (opcode 0) or a
// connection event (opcode 1) that clears the line. Bytes other than CR and
// LF go into a LINE_MAX-1 byte line store, one item per cycle; a byte that
// arrives with the store full clears the line and is lost. LF sends the
// line out trimmed of spaces and tabs, lowercased, cut at the first zero
// byte, or "none" if nothing is left, with o_last_char on the final
// character. During the readout o_ready stays low until the last character
// is emitted, longer while the output side stalls: the characters come one
// per cycle when the output is free, through the store's single registered
// read port and the output register. The last character may wait in the
// output register while new bytes are already taken.
`default_nettype none

module command_line_assembler #(
    parameter int LINE_MAX = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_data_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_cmd_char,
    output logic            o_last_char
);

    cla_pkg::t_dp_cmd w_cmd;
    cla_pkg::t_dp_sts w_sts;

    cla_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .o_ready  (o_ready),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd)
    );

    cla_dpath #(
        .LINE_MAX (LINE_MAX)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_data_byte),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cmd_char  (o_cmd_char),
        .o_last_char (o_last_char)
    );

endmodule

`default_nettype wire

// ----- hdl/cla_checker.sv -----
`default_nettype none

`include "command_line_assembler_macros.svh"

module cla_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       i_opcode,
    input wire logic [7:0] i_data_byte,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_cmd_char,
    input wire logic       o_last_char
);

    logic       w_in_acc;
    logic       w_lf_acc;
    logic       w_out_stall;
    logic [8:0] w_out_word;

    assign w_in_acc = i_valid && o_ready;
    assign w_lf_acc = w_in_acc && (i_opcode == cla_pkg::OP_DATA)
                      && (i_data_byte == cla_pkg::CH_LF);
    assign w_out_stall = o_valid && !i_ready;
    assign w_out_word  = {o_last_char, o_cmd_char};

    // stalled result holds
    `CLA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_valid && $stable(w_out_word))
    // a command still being sent keeps the input closed
    `CLA_ASSERT_NOW(a_busy_mid_cmd, i_clk, i_rst_n, o_valid && !o_last_char, !o_ready)
    // a line end starts a readout
    `CLA_ASSERT_NEXT(a_lf_stalls, i_clk, i_rst_n, w_lf_acc, !o_ready)
    // any other item leaves the input open
    `CLA_ASSERT_NEXT(a_byte_streams, i_clk, i_rst_n, w_in_acc && !w_lf_acc, o_ready)

endmodule

bind command_line_assembler cla_checker u_cla_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_opcode    (i_opcode),
    .i_data_byte (i_data_byte),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_cmd_char  (o_cmd_char),
    .o_last_char (o_last_char)
);

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int LINE_MAX     = 32;
    localparam int STORE_DEPTH  = LINE_MAX - 1;
    localparam int RANDOM_ITEMS = 430;

    typedef struct {
        bit         hold;   // wait here until every pending char is out
        logic       opcode;
        logic [7:0] data;
    } t_line_item;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_cmd_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_opcode;
    logic [7:0] i_data_byte;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_cmd_char;
    logic       o_last_char;

    command_line_assembler #(
        .LINE_MAX(LINE_MAX)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_opcode   (i_opcode),
        .i_data_byte(i_data_byte),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_cmd_char (o_cmd_char),
        .o_last_char(o_last_char)
    );

    t_line_item byte_q[$];
    t_cmd_char  cmd_chars_due[$];
    int         fail_count;
    int         items_taken;
    int         stim_items;
    bit         in_taken;

    // shadow of the line being assembled
    logic [7:0] line_buf [STORE_DEPTH];
    int         line_fill;
    int         first_text;
    int         end_text;
    bit         nul_seen;

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] lower_of(input logic [7:0] c);
        if (c >= cla_pkg::CH_UP_A && c <= cla_pkg::CH_UP_Z) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic bit is_space_or_tab(input logic [7:0] c);
        return c == cla_pkg::CH_SPACE || c == cla_pkg::CH_TAB;
    endfunction

    task automatic clear_shadow();
        line_fill  = 0;
        first_text = 0;
        end_text   = 0;
        nul_seen   = 1'b0;
    endtask

    task automatic push_cmd_char(input logic [7:0] c, input logic last);
        t_cmd_char cc;
        cc.ch   = c;
        cc.last = last;
        cmd_chars_due.push_back(cc);
    endtask

    // Follows one accepted item and queues the command chars it releases.
    task automatic assemble_line(input logic op, input logic [7:0] c);
        if (op == cla_pkg::OP_CLEAR) begin
            clear_shadow();
        end else if (c == cla_pkg::CH_CR) begin
            // dropped
        end else if (c == cla_pkg::CH_LF) begin
            if (end_text == 0) begin
                for (int k = 0; k < 4; k++) begin
                    push_cmd_char(cla_pkg::NONE_TEXT[k], k == 3);
                end
            end else begin
                for (int k = first_text; k < end_text; k++) begin
                    push_cmd_char(lower_of(line_buf[k]), k + 1 == end_text);
                end
            end
            clear_shadow();
        end else if (line_fill < STORE_DEPTH) begin
            line_buf[line_fill] = c;
            if (!nul_seen) begin
                if (c == cla_pkg::CH_NUL) begin
                    nul_seen = 1'b1;
                end else if (!is_space_or_tab(c)) begin
                    if (end_text == 0) begin
                        first_text = line_fill;
                    end
                    end_text = line_fill + 1;
                end
            end
            line_fill++;
        end else begin
            // store full: byte lost, line cleared
            clear_shadow();
        end
    endtask

    // Output check first, then prediction: a char leaving now never
    // comes from the item taken at the same edge.
    always @(posedge i_clk) begin
        t_cmd_char want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (cmd_chars_due.size() == 0) begin
                    fail_count++;
                    $error("unexpected cmd_char %h last_char %b", o_cmd_char, o_last_char);
                end else begin
                    want = cmd_chars_due.pop_front();
                    if (o_cmd_char !== want.ch) begin
                        fail_count++;
                        $error("cmd_char: expected %h, got %h", want.ch, o_cmd_char);
                    end
                    if (o_last_char !== want.last) begin
                        fail_count++;
                        $error("last_char: expected %b, got %b", want.last, o_last_char);
                    end
                end
            end
            if (i_valid && o_ready) begin
                items_taken++;
                assemble_line(i_opcode, i_data_byte);
            end
            in_taken <= i_valid && o_ready;
        end
    end

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        t_line_item it;
        logic       next_valid;
        if (i_rst_n && (!i_valid || in_taken)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (byte_q.size() > 0) begin
                if (byte_q[0].hold) begin
                    if (cmd_chars_due.size() == 0) begin
                        void'(byte_q.pop_front());
                    end
                end else begin
                    it = byte_q.pop_front();
                    i_opcode    <= it.opcode;
                    i_data_byte <= it.data;
                    next_valid  = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 7))
                            0, 1:    gap_left = 0;
                            7:       gap_left = $urandom_range(10, 30);
                            default: gap_left = $urandom_range(1, 6);
                        endcase
                    end
                end
            end
            i_valid <= next_valid;
        end
    end

    // Receiver: a random stall rate for each phase, plus two long hold-offs
    // taken while the sender is still busy.
    int stall_pct     = 0;
    int phase_cycles  = 0;
    int holdoff_left  = 0;
    int holdoffs_done = 0;
    int holdoff_at    = 150;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_ready <= 1'b0;
            end else if (holdoffs_done < 2 && items_taken >= holdoff_at) begin
                holdoffs_done++;
                holdoff_at   = holdoff_at + 180;
                holdoff_left = 300;
                i_ready <= 1'b0;
            end else begin
                phase_cycles++;
                if (phase_cycles >= 50) begin
                    phase_cycles = 0;
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        3: stall_pct = 85;
                    endcase
                end
                i_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic push_item(input logic op, input logic [7:0] c);
        t_line_item it;
        it.hold   = 1'b0;
        it.opcode = op;
        it.data   = c;
        byte_q.push_back(it);
        stim_items++;
    endtask

    task automatic push_byte(input logic [7:0] c);
        push_item(cla_pkg::OP_DATA, c);
    endtask

    task automatic push_clear(input logic [7:0] c);
        push_item(cla_pkg::OP_CLEAR, c);
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            push_byte(s[k]);
        end
    endtask

    task automatic push_hold();
        t_line_item it;
        it.hold   = 1'b1;
        it.opcode = cla_pkg::OP_DATA;
        it.data   = cla_pkg::CH_NUL;
        byte_q.push_back(it);
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] edges [9] = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'hFF, 8'h80, 8'h7F,
                                  cla_pkg::CH_UP_A, cla_pkg::CH_UP_Z};
        case ($urandom_range(0, 11))
            0:       return cla_pkg::CH_SPACE;
            1:       return cla_pkg::CH_TAB;
            2, 3, 4: return cla_pkg::CH_UP_A + 8'($urandom_range(0, 25));
            5, 6:    return 8'h61 + 8'($urandom_range(0, 25));
            7:       return 8'($urandom_range(0, 255));
            8:       return edges[$urandom_range(0, 8)];
            9:       return cla_pkg::CH_CR;
            10:      return ($urandom_range(0, 3) == 0) ? cla_pkg::CH_NUL
                                                        : 8'h30 + 8'($urandom_range(0, 9));
            default: return 8'h21 + 8'($urandom_range(0, 93));
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? cla_pkg::CH_SPACE : cla_pkg::CH_TAB;
    endfunction

    // Blanks, a body, blanks, then mostly a newline. Some lines run up
    // to or past the store size.
    task automatic push_random_line();
        int         total;
        int         lead;
        int         trail;
        logic [7:0] c;
        total = ($urandom_range(0, 7) == 0) ? $urandom_range(29, 33) : $urandom_range(0, 12);
        lead  = $urandom_range(0, 3);
        trail = $urandom_range(0, 3);
        if (lead > total) begin
            lead = total;
        end
        if (trail > total - lead) begin
            trail = total - lead;
        end
        for (int k = 0; k < total; k++) begin
            if (k < lead || k >= total - trail) begin
                c = pick_blank();
            end else begin
                c = pick_char();
                if (c == cla_pkg::CH_LF) begin
                    c = 8'h5F;
                end
            end
            push_byte(c);
        end
        case ($urandom_range(0, 9))
            0: begin
                push_clear(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) begin
                    push_byte(cla_pkg::CH_LF);
                end
            end
            1: ;  // runs on into the next line
            default: push_byte(cla_pkg::CH_LF);
        endcase
    endtask

    task automatic push_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                push_clear(8'($urandom_range(0, 255)));
            end else begin
                push_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        int lines;
        fail_count  = 0;
        items_taken = 0;
        stim_items  = 0;
        lines       = 0;
        clear_shadow();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_opcode    = cla_pkg::OP_DATA;
        i_data_byte = 8'h00;

        // trim, lowercase edges, CR drop
        push_text("\tAZ@[ \r\n");
        // empty and blank lines give "none"
        push_byte(cla_pkg::CH_LF);
        push_text(" \t\n");
        // high bytes pass through, text ends at the zero byte
        push_byte(8'hFF);
        push_byte(8'h80);
        push_text("X");
        push_byte(cla_pkg::CH_NUL);
        push_text("Y\n");
        push_byte(cla_pkg::CH_NUL);
        push_text("k\n");
        // connection event wipes the partial line
        push_text("a");
        push_clear(8'hFF);
        push_byte(cla_pkg::CH_LF);
        push_hold();

        stim_items = 0;
        while (stim_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                push_noise();
            end else begin
                push_random_line();
            end
            lines++;
            if (lines % 45 == 0) begin
                push_hold();
            end
        end
        push_byte(cla_pkg::CH_LF);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (cmd_chars_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- command_line_assembler.f -----
+incdir+hdl
hdl/cla_pkg.sv
hdl/cla_ctrl.sv
hdl/cla_dpath.sv
hdl/command_line_assembler.sv
hdl/cla_checker.sv
dv/testbench.sv
